### rtl/core/area_average_line_downscaler_macros.svh
// assertion helpers for the line downscaler
`ifndef AREA_AVERAGE_LINE_DOWNSCALER_MACROS_SVH
`define AREA_AVERAGE_LINE_DOWNSCALER_MACROS_SVH

// same-cycle implication, checked out of reset
`define ALD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ald check failed");

// next-cycle implication, checked out of reset
`define ALD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ald check failed");

`endif

### rtl/core/ald_pkg.sv
`timescale 1ns / 1ps
package ald_pkg;

  localparam int SAMPLE_W = 16;
  localparam int PIXEL_W  = 16;
  localparam int CFG_W    = 15;
  localparam int SUM_W    = 31;
  localparam int TOTAL_W  = 32;

  typedef enum logic [0:0] {
    REG_WEIGHT_PER_SAMPLE = 1'b0,
    REG_WEIGHT_PER_OUTPUT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic               valid;
    logic [TOTAL_W-1:0] total;
  } ald_push_t;

endpackage

### rtl/core/ald_front.sv
`timescale 1ns / 1ps
module ald_front import ald_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int RATIO_BITS  = 15
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_index,
  input  logic [CFG_W-1:0]      cfg_wdata,
  input  logic                  push,
  output logic                  full,
  input  logic [SAMPLE_W-1:0]   in_sample_in,
  input  logic                  in_line_start,
  output ald_push_t             q_push,
  input  logic                  q_full,
  output logic [RATIO_BITS-1:0] den
);

  localparam int PROD_W = SAMPLE_BITS + RATIO_BITS;

  typedef enum logic [1:0] {F_IDLE, F_MUL, F_ADD, F_REST} state_t;

  state_t                 state_r;
  logic [RATIO_BITS-1:0]  wps_r;
  logic [RATIO_BITS-1:0]  wpo_r;
  logic [SUM_W-1:0]       ws_r;
  logic [RATIO_BITS-1:0]  wn_r;
  logic [SAMPLE_BITS-1:0] s_r;
  logic [RATIO_BITS-1:0]  op_r;
  logic [RATIO_BITS-1:0]  rest_r;
  logic                   emit_r;
  logic [PROD_W-1:0]      prod_r;

  logic [RATIO_BITS-1:0]  num_raw;
  logic [RATIO_BITS-1:0]  num;
  logic [RATIO_BITS-1:0]  need_base;
  logic [RATIO_BITS-1:0]  need;
  logic                   emit;
  logic [RATIO_BITS-1:0]  rest;
  logic [TOTAL_W-1:0]     sum;

  always_comb begin
    den       = (wpo_r == '0) ? RATIO_BITS'(1) : wpo_r;
    num_raw   = (wps_r == '0) ? RATIO_BITS'(1) : wps_r;
    num       = (num_raw > den) ? den : num_raw;
    need_base = in_line_start ? den : wn_r;
    need      = (need_base == '0 || need_base > den) ? den : need_base;
    emit      = !(num < need);
    rest      = num - need;
    sum       = {1'b0, ws_r} + TOTAL_W'(prod_r);
  end

  assign full         = (state_r != F_IDLE);
  assign q_push.valid = (state_r == F_ADD) && emit_r && !q_full;
  assign q_push.total = sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wps_r <= RATIO_BITS'(1);
      wpo_r <= RATIO_BITS'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WEIGHT_PER_SAMPLE: wps_r <= cfg_wdata[RATIO_BITS-1:0];
        REG_WEIGHT_PER_OUTPUT: wpo_r <= cfg_wdata[RATIO_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      ws_r    <= '0;
      wn_r    <= RATIO_BITS'(1);
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (push) begin
            if (in_line_start) ws_r <= '0;
            wn_r    <= emit ? (den - rest) : (need - num);
            state_r <= F_MUL;
          end
        end
        F_MUL: state_r <= F_ADD;
        F_ADD: begin
          if (!emit_r) begin
            ws_r    <= sum[TOTAL_W-1] ? {SUM_W{1'b1}} : sum[SUM_W-1:0];
            state_r <= F_IDLE;
          end else if (!q_full) begin
            state_r <= F_REST;
          end
        end
        F_REST: begin
          ws_r    <= SUM_W'(s_r) * SUM_W'(rest_r);
          state_r <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  // operand capture and product, no reset needed
  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && push) begin
      s_r    <= in_sample_in[SAMPLE_BITS-1:0];
      op_r   <= emit ? need : num;
      rest_r <= rest;
      emit_r <= emit;
    end
    if (state_r == F_MUL) prod_r <= PROD_W'(s_r) * PROD_W'(op_r);
  end

endmodule

### rtl/core/ald_fifo.sv
`timescale 1ns / 1ps
module ald_fifo import ald_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  ald_push_t          wr,
  output logic               full,
  input  logic               rd_pop,
  output logic               empty,
  output logic [TOTAL_W-1:0] rd_data
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  logic [TOTAL_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]   wp_r;
  logic [PTR_W-1:0]   rp_r;
  logic [PTR_W:0]     cnt_r;
  logic               do_wr;
  logic               do_rd;

  assign full    = (cnt_r == (PTR_W+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr.valid && !full;
  assign do_rd   = rd_pop && !empty;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wp_r] <= wr.total;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= wp_r + 1'b1;
      if (do_rd) rp_r <= rp_r + 1'b1;
      case ({do_wr, do_rd})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

### rtl/core/ald_divider.sv
`timescale 1ns / 1ps
module ald_divider import ald_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int RATIO_BITS  = 15
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [RATIO_BITS-1:0] den,
  input  logic                  q_empty,
  input  logic [TOTAL_W-1:0]    q_data,
  output logic                  q_pop,
  output logic                  empty,
  input  logic                  pop,
  output logic [PIXEL_W-1:0]    out_pixel_out
);

  localparam int CNT_W = $clog2(TOTAL_W);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_HOLD} state_t;

  state_t                 state_r;
  logic [CNT_W-1:0]       cnt_r;
  logic [TOTAL_W-1:0]     quo_r;
  logic [RATIO_BITS-1:0]  rem_r;
  logic                   valid_r;
  logic [SAMPLE_BITS-1:0] pix_r;

  logic [RATIO_BITS:0]    rem_sh;
  logic                   ge;
  logic                   load_out;
  logic [SAMPLE_BITS-1:0] sat_q;

  always_comb begin
    rem_sh   = {rem_r, quo_r[TOTAL_W-1]};
    ge       = (rem_sh >= {1'b0, den});
    load_out = (state_r == D_HOLD) && (!valid_r || pop);
    sat_q    = (|quo_r[TOTAL_W-1:SAMPLE_BITS]) ? {SAMPLE_BITS{1'b1}}
                                                : quo_r[SAMPLE_BITS-1:0];
  end

  assign q_pop         = (state_r == D_IDLE) && !q_empty;
  assign empty         = !valid_r;
  assign out_pixel_out = PIXEL_W'(pix_r);

  // restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      valid_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        D_IDLE: begin
          if (!q_empty) begin
            cnt_r   <= CNT_W'(TOTAL_W - 1);
            state_r <= D_RUN;
          end
        end
        D_RUN: begin
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) state_r <= D_HOLD;
        end
        D_HOLD: begin
          if (load_out) state_r <= D_IDLE;
        end
        default: state_r <= D_IDLE;
      endcase
      if (load_out)  valid_r <= 1'b1;
      else if (pop)  valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == D_IDLE) begin
      quo_r <= q_data;
      rem_r <= '0;
    end else if (state_r == D_RUN) begin
      quo_r <= {quo_r[TOTAL_W-2:0], ge};
      rem_r <= ge ? RATIO_BITS'(rem_sh - {1'b0, den}) : rem_sh[RATIO_BITS-1:0];
    end
    if (load_out) pix_r <= sat_q;
  end

endmodule

### rtl/core/area_average_line_downscaler.sv
`timescale 1ns / 1ps
// Area-average line downscaler. Each accepted sample adds sample * weight_per_sample
// to a running sum; when an output's weight of weight_per_output is complete, the
// sum is queued and divided by weight_per_output (floor, saturated to the sample
// range). The front multiplies and adds each sample, and for one that closes an
// output waits while the queue is full, then keeps the rest; full is high while it
// works. A restoring divider yields one quotient bit per clock over the 32-bit sum;
// a two-word queue between front and back lets the front run ahead by two outputs.
// The user must write configuration only while idle; the block does not enforce it.
module area_average_line_downscaler import ald_pkg::*; #(
  parameter int SAMPLE_BITS = 16,
  parameter int RATIO_BITS  = 15
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_index,
  input  logic [CFG_W-1:0]    cfg_wdata,
  input  logic                push,
  output logic                full,
  input  logic [SAMPLE_W-1:0] in_sample_in,
  input  logic                in_line_start,
  output logic                empty,
  input  logic                pop,
  output logic [PIXEL_W-1:0]  out_pixel_out
);

  `include "area_average_line_downscaler_macros.svh"

  ald_push_t             q_push;
  logic                  q_full;
  logic                  q_empty;
  logic                  q_pop;
  logic [TOTAL_W-1:0]    q_data;
  logic [RATIO_BITS-1:0] den;

  ald_front #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .RATIO_BITS (RATIO_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .push         (push),
    .full         (full),
    .in_sample_in (in_sample_in),
    .in_line_start(in_line_start),
    .q_push       (q_push),
    .q_full       (q_full),
    .den          (den)
  );

  ald_fifo u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr     (q_push),
    .full   (q_full),
    .rd_pop (q_pop),
    .empty  (q_empty),
    .rd_data(q_data)
  );

  ald_divider #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .RATIO_BITS (RATIO_BITS)
  ) u_div (
    .clk          (clk),
    .rst_n        (rst_n),
    .den          (den),
    .q_empty      (q_empty),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .empty        (empty),
    .pop          (pop),
    .out_pixel_out(out_pixel_out)
  );

  `ALD_ASSERT_NOW(a_no_push_when_full, q_push.valid, !q_full)
  `ALD_ASSERT_NEXT(a_busy_after_accept, push && !full, full)
  `ALD_ASSERT_NOW(a_den_nonzero, 1'b1, den != '0)
  `ALD_ASSERT_NOW(a_pop_only_queued, q_pop, !q_empty)

endmodule

### dv/area_average_line_downscaler_tb.sv
`timescale 1ns / 1ps
module area_average_line_downscaler_tb;
  import ald_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int BACKLOG_HOLD   = 300;
  localparam int SETTLE_CYCLES  = 16;
  localparam int DRAIN_CYCLES   = 80;
  localparam int RANDOM_PHASES  = 14;
  localparam logic [CFG_W-1:0]    RATIO_MAX  = '1;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;
  localparam logic [63:0]         SUM_CEIL   = 64'h7FFF_FFFF;

  typedef struct packed {
    bit                  set_ratio;
    logic [CFG_W-1:0]    wps;
    logic [CFG_W-1:0]    wpo;
    logic [SAMPLE_W-1:0] sample;
    bit                  line_start;
    bit                  typed;
    logic [PIXEL_W-1:0]  pixel;
  } step_row_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [0:0]          cfg_index;
  logic [CFG_W-1:0]    cfg_wdata;
  logic                push;
  logic                full;
  logic [SAMPLE_W-1:0] in_sample_in;
  logic                in_line_start;
  logic                empty;
  logic                pop;
  logic [PIXEL_W-1:0]  out_pixel_out;

  // shadow of the ratio registers and the running line state
  logic [CFG_W-1:0] cur_wps;
  logic [CFG_W-1:0] cur_wpo;
  logic [63:0]      run_sum;
  logic [CFG_W-1:0] run_need;

  logic [PIXEL_W-1:0] pixel_q[$];
  step_row_t          plan_q[$];

  bit no_gaps;
  bit sender_gaps;
  bit backlog_req;
  bit backlog_done;
  int samples_sent;
  int pixels_checked;
  int ratio_settings;
  int mismatches;

  area_average_line_downscaler DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .push          (push),
    .full          (full),
    .in_sample_in  (in_sample_in),
    .in_line_start (in_line_start),
    .empty         (empty),
    .pop           (pop),
    .out_pixel_out (out_pixel_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit area_pixel(input logic [SAMPLE_W-1:0] s, input bit ls,
                                    output logic [PIXEL_W-1:0] pix);
    logic [CFG_W-1:0] den;
    logic [CFG_W-1:0] num;
    logic [CFG_W-1:0] need;
    logic [CFG_W-1:0] rest;
    logic [63:0]      total;
    logic [63:0]      quo;
    den = (cur_wpo == '0) ? 15'd1 : cur_wpo;
    num = (cur_wps == '0) ? 15'd1 : cur_wps;
    pix = '0;
    if (num > den) num = den;
    if (ls) begin
      run_sum = '0;
      run_need = den;
    end
    need = (run_need == '0 || run_need > den) ? den : run_need;
    if (num < need) begin
      total = run_sum + s * num;
      run_sum = (total > SUM_CEIL) ? SUM_CEIL : total;
      run_need = need - num;
      return 1'b0;
    end
    total = run_sum + s * need;
    quo = total / den;
    rest = num - need;
    pix = (quo > SAMPLE_MAX) ? SAMPLE_MAX : quo[PIXEL_W-1:0];
    total = s * rest;
    run_sum = (total > SUM_CEIL) ? SUM_CEIL : total;
    run_need = den - rest;
    return 1'b1;
  endfunction

  task automatic ratio_row(input logic [CFG_W-1:0] wps, input logic [CFG_W-1:0] wpo);
    step_row_t r;
    r = '0;
    r.set_ratio = 1'b1;
    r.wps = wps;
    r.wpo = wpo;
    plan_q.push_back(r);
  endtask

  task automatic sample_row(input logic [SAMPLE_W-1:0] s, input bit ls, input bit typed,
                            input logic [PIXEL_W-1:0] pix);
    step_row_t r;
    r = '0;
    r.sample = s;
    r.line_start = ls;
    r.typed = typed;
    r.pixel = pix;
    plan_q.push_back(r);
  endtask

  task automatic set_ratio(input logic [CFG_W-1:0] wps, input logic [CFG_W-1:0] wpo);
    push <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_WEIGHT_PER_SAMPLE;
    cfg_wdata <= wps;
    @(posedge clk);
    cfg_index <= REG_WEIGHT_PER_OUTPUT;
    cfg_wdata <= wpo;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_wps = wps;
    cur_wpo = wpo;
    ratio_settings++;
  endtask

  task automatic send_sample(input logic [SAMPLE_W-1:0] s, input bit ls, input bit typed,
                             input logic [PIXEL_W-1:0] typed_pix);
    bit                 taken;
    bit                 fires;
    logic [PIXEL_W-1:0] pix;
    if (!no_gaps && sender_gaps && $urandom_range(0, 7) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    push <= 1'b1;
    in_sample_in <= s;
    in_line_start <= ls;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !full;
      @(posedge clk);
    end
    fires = area_pixel(s, ls, pix);
    if (typed) pixel_q.push_back(typed_pix);
    else if (fires) pixel_q.push_back(pix);
    samples_sent++;
  endtask

  initial begin : pixel_sink
    bit                 got;
    logic [PIXEL_W-1:0] seen;
    logic [PIXEL_W-1:0] want;
    pop = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (backlog_req && !backlog_done) begin
        pop <= 1'b0;
        for (int n = 0; n < BACKLOG_HOLD; n++) @(posedge clk);
        backlog_done = 1'b1;
      end else if (!no_gaps && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
      pop <= 1'b1;
      @(negedge clk);
      got = !empty;
      seen = out_pixel_out;
      @(posedge clk);
      if (got) begin
        pixels_checked++;
        if (pixel_q.size() == 0) begin
          $display("%0t: pixel_out %0d with no word expected", $time, seen);
          mismatches++;
        end else begin
          want = pixel_q.pop_front();
          if (want !== seen) begin
            $display("%0t: pixel_out mismatch, expected %0d, actual %0d", $time, want, seen);
            mismatches++;
          end
        end
      end
    end
  end

  initial begin : watchdog
    int stuck;
    stuck = 0;
    forever begin
      @(negedge clk);
      if ((push && !full) || (pop && !empty) || cfg_we) stuck = 0;
      else stuck++;
      if (stuck >= WATCHDOG_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, stuck);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0]    wps;
    logic [CFG_W-1:0]    wpo;
    logic [SAMPLE_W-1:0] s;
    int                  phase_len;
    int                  line_left;
    bit                  ls;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_WEIGHT_PER_SAMPLE;
    cfg_wdata = '0;
    push = 1'b0;
    in_sample_in = '0;
    in_line_start = 1'b0;
    cur_wps = 15'd1;
    cur_wpo = 15'd1;
    run_sum = '0;
    run_need = 15'd1;
    no_gaps = 1'b0;
    sender_gaps = 1'b1;
    backlog_req = 1'b0;
    backlog_done = 1'b0;
    samples_sent = 0;
    pixels_checked = 0;
    ratio_settings = 0;
    mismatches = 0;

    // reset ratio is 1/1: every sample comes straight out
    sample_row(16'h0000, 1'b0, 1'b1, 16'h0000);
    sample_row(16'hFFFF, 1'b0, 1'b1, 16'hFFFF);
    sample_row(16'h5555, 1'b1, 1'b1, 16'h5555);
    sample_row(16'hAAAA, 1'b0, 1'b1, 16'hAAAA);
    // zero registers behave as one
    ratio_row(15'd0, 15'd0);
    sample_row(16'd1234, 1'b1, 1'b1, 16'd1234);
    sample_row(16'hFFFF, 1'b0, 1'b1, 16'hFFFF);
    // upscale ratio clamps to one word per sample
    ratio_row(15'd5, 15'd3);
    sample_row(16'h8001, 1'b1, 1'b1, 16'h8001);
    sample_row(16'd7, 1'b0, 1'b1, 16'd7);
    ratio_row(RATIO_MAX, RATIO_MAX);
    sample_row(16'hFFFF, 1'b1, 1'b1, 16'hFFFF);
    sample_row(16'd1, 1'b0, 1'b1, 16'd1);
    ratio_row(15'd1, 15'd3);
    sample_row(16'd10, 1'b1, 1'b0, '0);
    sample_row(16'd20, 1'b0, 1'b0, '0);
    sample_row(16'd31, 1'b0, 1'b0, '0);
    sample_row(16'hFFFF, 1'b1, 1'b0, '0);
    sample_row(16'hFFFF, 1'b0, 1'b0, '0);
    // divisor shrunk mid-line, quotient saturates
    ratio_row(15'd1, 15'd2);
    sample_row(16'hFFFF, 1'b0, 1'b1, 16'hFFFF);
    // needed weight above the new divisor
    ratio_row(15'd2, 15'd7);
    sample_row(16'd100, 1'b1, 1'b0, '0);
    ratio_row(15'd1, 15'd3);
    sample_row(16'd50, 1'b0, 1'b0, '0);
    sample_row(16'd60, 1'b0, 1'b0, '0);
    sample_row(16'd3, 1'b0, 1'b0, '0);
    ratio_row(15'd32766, RATIO_MAX);
    sample_row(16'hFFFF, 1'b1, 1'b0, '0);
    sample_row(16'hFFFF, 1'b0, 1'b0, '0);
    sample_row(16'h0000, 1'b0, 1'b0, '0);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan_q[i]) begin
      if (plan_q[i].set_ratio) set_ratio(plan_q[i].wps, plan_q[i].wpo);
      else send_sample(plan_q[i].sample, plan_q[i].line_start, plan_q[i].typed,
                       plan_q[i].pixel);
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin wps = RATIO_MAX; wpo = RATIO_MAX; end
        1: begin wps = '0; wpo = '0; end
        2: begin wps = 15'd3; wpo = 15'd3; end
        3: begin
          wpo = CFG_W'($urandom_range(1, 32766));
          wps = CFG_W'($urandom_range(wpo + 1, 32767));
        end
        4: begin wps = RATIO_MAX; wpo = 15'd1; end
        5: begin wpo = RATIO_MAX; wps = CFG_W'($urandom_range(16384, 32767)); end
        6: begin
          wpo = CFG_W'($urandom_range(2, 32767));
          wps = CFG_W'(wpo - $urandom_range(0, wpo / 4));
        end
        7: begin wps = 15'd1; wpo = 15'd2; end
        default: begin
          wpo = CFG_W'($urandom_range(1, 16));
          wps = CFG_W'(($urandom_range(0, 3) == 0) ? $urandom_range(wpo, 40)
                                                   : $urandom_range(1, wpo));
        end
      endcase
      set_ratio(wps, wpo);
      no_gaps = (ph >= RANDOM_PHASES - 2);
      sender_gaps = ($urandom_range(0, 3) != 0);
      if (ph == 2) begin
        sender_gaps = 1'b0;
        backlog_req = 1'b1;
      end
      phase_len = $urandom_range(80, 110);
      line_left = $urandom_range(1, 40);
      for (int k = 0; k < phase_len; k++) begin
        ls = 1'b0;
        if (k == 0) ls = 1'($urandom_range(0, 1));
        else if (line_left == 0) begin
          ls = 1'b1;
          line_left = $urandom_range(1, 40);
        end else if ($urandom_range(0, 24) == 0) ls = 1'b1;
        line_left--;
        case ($urandom_range(0, 7))
          0: s = '0;
          1: s = SAMPLE_MAX;
          default: s = SAMPLE_W'($urandom_range(0, 65535));
        endcase
        send_sample(s, ls, 1'b0, '0);
      end
    end

    push <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("%0d samples sent over %0d ratio settings, %0d pixels checked",
             samples_sent, ratio_settings, pixels_checked);
    $display("included zero and upscale ratios, mid-line ratio changes and a stalled output");
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
